// File: rtl/sida_pkg.sv
`default_nettype none
package sida_pkg;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 6;
    localparam int unsigned NDIG    = 10;
    localparam int unsigned DIG_W   = 4;
    localparam int unsigned CNT_W   = 4;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

    // One item in the converter after its magnitude is known.
    typedef struct packed {
        logic                       neg;
        logic [NDIG-1:0][DIG_W-1:0] bcd;
    } t_bcd_item;

    // One item after the digit count is known.
    typedef struct packed {
        logic                       neg;
        logic [NDIG-1:0][DIG_W-1:0] bcd;
        logic [CNT_W-1:0]           ndig;
    } t_run_item;

    // Add-3 correction of one BCD digit before a shift.
    function automatic logic [DIG_W-1:0] add3(input logic [DIG_W-1:0] d);
        add3 = (d >= 4'd5) ? d + 4'd3 : d;
    endfunction
endpackage
`default_nettype wire

// File: rtl/sida_bcd.sv
`default_nettype none
// Pipelined double-dabble: magnitude to ten BCD digits, four bits per stage.
module sida_bcd (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [sida_pkg::VALUE_W-1:0] i_value,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output sida_pkg::t_bcd_item              o_item
);
    import sida_pkg::*;

    localparam int unsigned NST  = 8;
    localparam int unsigned BPS  = VALUE_W / NST;

    logic [NST-1:0]                         r_vld;
    logic [NST-1:0]                         r_neg;
    logic [NST-1:0][VALUE_W-1:0]            r_bin;
    logic [NST-1:0][NDIG-1:0][DIG_W-1:0]    r_bcd;
    logic [NST-1:0]                         w_adv;
    logic [VALUE_W-1:0]                     w_mag;
    logic [NST-1:0]                         w_src_vld;
    logic [NST-1:0]                         w_src_neg;
    logic [NST-1:0][VALUE_W-1:0]            w_src_bin;
    logic [NST-1:0][NDIG-1:0][DIG_W-1:0]    w_src_bcd;

    // A stage moves when it is empty or the stage after it is moving.
    always_comb begin
        w_adv[NST-1] = !r_vld[NST-1] || i_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            w_adv[s] = !r_vld[s] || w_adv[s+1];
        end
    end
    assign o_ready = w_adv[0];
    assign w_mag   = i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;

    // The first stage takes the new item, every other stage the one before it.
    always_comb begin
        w_src_vld[0] = i_valid;
        w_src_neg[0] = i_value[VALUE_W-1];
        w_src_bin[0] = w_mag;
        w_src_bcd[0] = '0;
        for (int s = 1; s < NST; s++) begin
            w_src_vld[s] = r_vld[s-1];
            w_src_neg[s] = r_neg[s-1];
            w_src_bin[s] = r_bin[s-1];
            w_src_bcd[s] = r_bcd[s-1];
        end
    end

    // Each stage shifts four magnitude bits into the BCD register.
    always_ff @(posedge i_clk) begin
        logic [VALUE_W-1:0]              t_b;
        logic [NDIG-1:0][DIG_W-1:0]      t_d;
        logic [NDIG*DIG_W-1:0]           t_f;
        for (int s = 0; s < NST; s++) begin
            if (w_adv[s]) begin
                t_b = w_src_bin[s];
                t_d = w_src_bcd[s];
                for (int k = 0; k < BPS; k++) begin
                    for (int j = 0; j < NDIG; j++) begin
                        t_d[j] = add3(t_d[j]);
                    end
                    t_f = t_d;
                    t_d = {t_f[NDIG*DIG_W-2:0], t_b[VALUE_W-1]};
                    t_b = {t_b[VALUE_W-2:0], 1'b0};
                end
                r_bin[s] <= t_b;
                r_bcd[s] <= t_d;
                r_neg[s] <= w_src_neg[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NST; s++) begin
                if (w_adv[s]) begin
                    r_vld[s] <= w_src_vld[s];
                end
            end
        end
    end

    assign o_valid    = r_vld[NST-1];
    assign o_item.neg = r_neg[NST-1];
    assign o_item.bcd = r_bcd[NST-1];
endmodule
`default_nettype wire

// File: rtl/sida_count.sv
`default_nettype none
// Counts significant digits of the BCD word, one register stage.
module sida_count (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  sida_pkg::t_bcd_item      i_item,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output sida_pkg::t_run_item      o_item
);
    import sida_pkg::*;

    logic             r_vld;
    t_run_item        r_item;
    logic [CNT_W-1:0] w_cnt;

    assign o_ready = !r_vld || i_ready;

    // Highest nonzero digit sets the count; zero still has one digit.
    always_comb begin
        w_cnt = CNT_W'(1);
        for (int j = 1; j < NDIG; j++) begin
            if (i_item.bcd[j] != '0) begin
                w_cnt = CNT_W'(j + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item.neg  <= i_item.neg;
            r_item.bcd  <= i_item.bcd;
            r_item.ndig <= w_cnt;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;
endmodule
`default_nettype wire

// File: rtl/sida_emit.sv
`default_nettype none
// Emits the sign and digits of one item, one character per cycle while the output is taken.
module sida_emit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  sida_pkg::t_run_item             i_item,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [sida_pkg::CHAR_W-1:0]     o_character,
    output logic                            o_last
);
    import sida_pkg::*;

    logic                       r_busy;
    logic                       r_sign;
    logic [CNT_W-1:0]           r_pos;
    logic [NDIG-1:0][DIG_W-1:0] r_bcd;
    logic                       r_ov;
    logic [CHAR_W-1:0]          r_ch;
    logic                       r_last;
    logic                       w_take;
    logic                       w_put;
    logic [DIG_W-1:0]           w_dig;
    logic [CHAR_W-1:0]          n_ch;
    logic                       n_last;

    // The output register may load when empty or being taken.
    assign w_put   = r_busy && (!r_ov || i_ready);
    assign o_ready = !r_busy || (w_put && !r_sign && r_pos == CNT_W'(0));
    assign w_take  = i_valid && o_ready;
    assign w_dig   = r_bcd[r_pos[DIG_W-1:0]];

    always_comb begin
        if (r_sign) begin
            n_ch   = CH_MINUS;
            n_last = 1'b0;
        end else begin
            n_ch   = CH_ZERO + CHAR_W'(w_dig);
            n_last = (r_pos == CNT_W'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
            end else if (w_put && !r_sign && r_pos == CNT_W'(0)) begin
                r_busy <= 1'b0;
            end
            if (w_put) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Walk the digits from the most significant one down.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sign <= i_item.neg;
            r_pos  <= i_item.ndig - 1'b1;
            r_bcd  <= i_item.bcd;
        end else if (w_put) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else begin
                r_pos <= r_pos - 1'b1;
            end
        end
        if (w_put) begin
            r_ch   <= n_ch;
            r_last <= n_last;
        end
    end

    assign o_valid     = r_ov;
    assign o_character = r_ch;
    assign o_last      = r_last;

    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_character != CH_MINUS))
        else $error("last flag on minus sign");
    a_sign_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_put && r_sign) |=> (r_busy && !r_sign))
        else $error("sign not followed by digits");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_put && n_last) |=> (o_valid && o_last))
        else $error("final character lost");
endmodule
`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii.sv
`default_nettype none
// Converts a signed 32-bit value to its decimal ASCII text, one character per
// output item: an optional minus sign, then digits most significant first with
// no leading zeros, last set on the final digit. A nine-stage pipeline (eight
// double-dabble stages, four bits each, and a digit count stage) feeds a
// character emitter; a number gives 1 to 11 characters, and the emitter takes
// the next number as it gives the final digit of the one before.
module signed_int_to_decimal_ascii (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [sida_pkg::VALUE_W-1:0] i_value,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [sida_pkg::CHAR_W-1:0]       o_character,
    output logic                              o_last
);
    import sida_pkg::*;

    logic      w_bv, w_br, w_cv, w_cr;
    t_bcd_item w_bi;
    t_run_item w_ci;

    sida_bcd u_bcd (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_value,
        .o_valid(w_bv), .i_ready(w_br), .o_item(w_bi)
    );
    sida_count u_count (
        .i_clk, .i_rst_n, .i_valid(w_bv), .o_ready(w_br), .i_item(w_bi),
        .o_valid(w_cv), .i_ready(w_cr), .o_item(w_ci)
    );
    sida_emit u_emit (
        .i_clk, .i_rst_n, .i_valid(w_cv), .o_ready(w_cr), .i_item(w_ci),
        .o_valid, .i_ready, .o_character, .o_last
    );
endmodule
`default_nettype wire
